/* src/rtls_pkg.sv */
// Shared types and constants for the radio transmitter link supervisor.
`default_nettype none

package rtls_pkg;

  // Radio status byte bit positions.
  localparam int unsigned ST_TX_DONE_BIT = 5;
  localparam int unsigned ST_MAX_RT_BIT  = 4;
  localparam int unsigned ST_TX_FULL_BIT = 0;
  localparam logic [7:0]  ST_PIPE_MASK   = 8'h0E;

  // FIFO status byte bit positions.
  localparam int unsigned FF_TX_FULL_BIT  = 5;
  localparam int unsigned FF_TX_EMPTY_BIT = 4;

  // Supervisor state carried from one poll to the next.
  typedef struct packed {
    logic        link_lost;
    logic        payload_pending;
    logic [7:0]  retry_counter;
    logic [15:0] sent_counter;
    logic [15:0] drop_counter;
    logic        link_led_state;
    logic        activity_state;
  } sup_state_t;

  // One poll as captured in the input register.
  typedef struct packed {
    logic [7:0] radio_status;
    logic [7:0] fifo_status;
    logic [7:0] write_status;
    logic [7:0] payload_byte;
  } poll_t;

  // One result beat.
  typedef struct packed {
    logic        issue_write;
    logic        byte_written;
    logic [7:0]  tx_byte;
    logic        clear_tx_done;
    logic        clear_max_retry;
    logic        flush_tx;
    logic        link_up;
    logic        link_led;
    logic        activity_led;
    logic [15:0] sent_total;
    logic [15:0] drop_total;
    logic [7:0]  retries_used;
  } result_t;

endpackage

`default_nettype wire

/* src/rtls_step.sv */
// Combinational next-state and result logic for one status poll.
`default_nettype none

module rtls_step
  import rtls_pkg::*;
(
  input  wire sup_state_t state_cur,
  input  wire poll_t      poll,
  input  wire logic [7:0] retry_limit,
  output sup_state_t      state_next,
  output result_t         result
);

  logic st;

  // Evaluate only the phase that matches the link state at the start of the poll.
  always_comb begin
    st         = 1'b0;
    state_next = state_cur;
    result     = '0;

    if (state_cur.link_lost) begin
      // Link lost: push the byte whenever the FIFO has room.
      if (!poll.fifo_status[FF_TX_FULL_BIT]) begin
        result.issue_write = 1'b1;
        if (!poll.write_status[ST_TX_FULL_BIT]) begin
          result.byte_written       = 1'b1;
          result.tx_byte            = poll.payload_byte;
          state_next.activity_state = ~state_next.activity_state;
        end else begin
          result.clear_max_retry = poll.write_status[ST_MAX_RT_BIT];
          result.flush_tx        = 1'b1;
        end
      end
      if (poll.radio_status[ST_TX_DONE_BIT]) begin
        state_next.link_led_state = 1'b1;
        result.clear_tx_done      = 1'b1;
        state_next.link_lost      = 1'b0;
      end
      if (poll.radio_status[ST_TX_FULL_BIT]) begin
        result.flush_tx = 1'b1;
      end
      if (poll.radio_status[ST_MAX_RT_BIT]) begin
        result.clear_max_retry = 1'b1;
      end
    end else begin
      // Linked: confirm the packet in flight.
      if (poll.radio_status[ST_TX_DONE_BIT] && state_cur.payload_pending) begin
        state_next.sent_counter    = state_cur.sent_counter + 16'd1;
        state_next.link_led_state  = 1'b1;
        result.clear_tx_done       = 1'b1;
        state_next.payload_pending = 1'b0;
      end
      // Issue the next payload when a pipe is flagged, nothing is in flight and the FIFO is empty.
      st = ((poll.radio_status & ST_PIPE_MASK) != 8'h00) && !state_next.payload_pending
           && poll.fifo_status[FF_TX_EMPTY_BIT];
      if (st) begin
        result.issue_write = 1'b1;
        if (!poll.write_status[ST_TX_FULL_BIT]) begin
          result.byte_written       = 1'b1;
          result.tx_byte            = poll.payload_byte;
          state_next.activity_state = ~state_next.activity_state;
        end else begin
          result.clear_max_retry = poll.write_status[ST_MAX_RT_BIT];
          result.flush_tx        = 1'b1;
        end
        state_next.payload_pending = 1'b1;
      end
      // Max-retry failure: retry up to the limit, then flush and drop the link.
      if (poll.radio_status[ST_MAX_RT_BIT]) begin
        state_next.drop_counter   = state_cur.drop_counter + 16'd1;
        state_next.link_led_state = 1'b0;
        if (state_cur.retry_counter < retry_limit) begin
          result.clear_max_retry   = 1'b1;
          state_next.retry_counter = state_cur.retry_counter + 8'd1;
        end else begin
          state_next.retry_counter   = 8'd0;
          result.flush_tx            = 1'b1;
          state_next.payload_pending = 1'b0;
          state_next.link_lost       = 1'b1;
        end
      end
    end

    // Status fields reflect the state after this poll.
    result.link_up      = ~state_next.link_lost;
    result.link_led     = state_next.link_led_state;
    result.activity_led = state_next.activity_state;
    result.sent_total   = state_next.sent_counter;
    result.drop_total   = state_next.drop_counter;
    result.retries_used = state_next.retry_counter;
  end

endmodule

`default_nettype wire

/* src/radio_tx_link_supervisor.sv */
// Top level of the radio transmitter link supervisor.
`default_nettype none

// Takes one radio status poll per beat and returns one result beat per poll.
// A poll is captured in an input register, evaluated against the supervisor
// state in combinational flag and counter logic, and written to an output
// register together with the state update, so one poll per cycle is sustained
// while the result channel does not stall. The retry limit register is
// written through the cfg channel, which is always ready; write it only while
// no poll is in flight. Reset leaves the link lost, all counters at zero and
// the retry limit at 20.
module radio_tx_link_supervisor
  import rtls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Poll channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  radio_status,
  input  wire logic [7:0]  fifo_status,
  input  wire logic [7:0]  write_status,
  input  wire logic [7:0]  payload_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             issue_write,
  output logic             byte_written,
  output logic [7:0]       tx_byte,
  output logic             clear_tx_done,
  output logic             clear_max_retry,
  output logic             flush_tx,
  output logic             link_up,
  output logic             link_led,
  output logic             activity_led,
  output logic [15:0]      sent_total,
  output logic [15:0]      drop_total,
  output logic [7:0]       retries_used,
  // Configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam logic [7:0] RETRY_RESET = 8'd20;

  logic       retry_limit;
  logic [7:0] retry_limit_q;
  logic       in_q_valid;
  poll_t      poll_q;
  sup_state_t state_q;
  sup_state_t state_next;
  result_t    result_next;
  result_t    result_q;
  logic       out_adv;

  assign retry_limit = cfg_valid && cfg_ready;
  assign cfg_ready   = 1'b1;

  // Retry limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit_q <= RETRY_RESET;
    end else if (retry_limit) begin
      retry_limit_q <= cfg_data;
    end
  end

  // The output register takes a new beat when empty or being drained.
  assign out_adv  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !out_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      poll_q <= '{radio_status: radio_status, fifo_status: fifo_status,
                  write_status: write_status, payload_byte: payload_byte};
    end
  end

  rtls_step u_step (
    .state_cur   (state_q),
    .poll        (poll_q),
    .retry_limit (retry_limit_q),
    .state_next  (state_next),
    .result      (result_next)
  );

  // Supervisor state commits when the poll moves to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= '{link_lost: 1'b1, payload_pending: 1'b0, retry_counter: 8'd0,
                   sent_counter: 16'd0, drop_counter: 16'd0,
                   link_led_state: 1'b0, activity_state: 1'b0};
    end else if (in_q_valid && out_adv) begin
      state_q <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_q_valid) begin
      result_q <= result_next;
    end
  end

  assign issue_write     = result_q.issue_write;
  assign byte_written    = result_q.byte_written;
  assign tx_byte         = result_q.tx_byte;
  assign clear_tx_done   = result_q.clear_tx_done;
  assign clear_max_retry = result_q.clear_max_retry;
  assign flush_tx        = result_q.flush_tx;
  assign link_up         = result_q.link_up;
  assign link_led        = result_q.link_led;
  assign activity_led    = result_q.activity_led;
  assign sent_total      = result_q.sent_total;
  assign drop_total      = result_q.drop_total;
  assign retries_used    = result_q.retries_used;

`ifndef SYNTHESIS
  // A byte is only reported as sent when a write was issued.
  a_written_needs_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_written |-> issue_write)
    else $error("byte_written without issue_write");

  // No byte goes out unless it was actually written.
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_written |-> tx_byte == 8'd0)
    else $error("tx_byte nonzero without a written byte");

  // The retry count is cleared whenever the link is down.
  a_retry_clear_when_lost: assert property (@(posedge clk) disable iff (rst)
    out_valid && !link_up |-> retries_used == 8'd0)
    else $error("retry count nonzero while link lost");

  // Supervisor state only moves when a poll is passed to the output register.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !(in_q_valid && out_adv) |=> $stable(state_q))
    else $error("state changed without a poll");
`endif

endmodule

`default_nettype wire

/* verif/tb_radio_tx_link_supervisor.sv */
// Testbench for the radio transmitter link supervisor: directed, back-to-back and random polls.
module tb_radio_tx_link_supervisor;
  import rtls_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  radio_status = 8'h00;
  logic [7:0]  fifo_status = 8'h00;
  logic [7:0]  write_status = 8'h00;
  logic [7:0]  payload_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        issue_write;
  logic        byte_written;
  logic [7:0]  tx_byte;
  logic        clear_tx_done;
  logic        clear_max_retry;
  logic        flush_tx;
  logic        link_up;
  logic        link_led;
  logic        activity_led;
  logic [15:0] sent_total;
  logic [15:0] drop_total;
  logic [7:0]  retries_used;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  // Shadow of the supervisor state and its retry limit, plus results still owed.
  sup_state_t  sup;
  logic [7:0]  retry_limit_shadow;
  result_t     results_due[$];
  int          fail_count = 0;
  int          stall_pct = 0;
  int          stall_run = 0;

  radio_tx_link_supervisor u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .radio_status    (radio_status),
    .fifo_status     (fifo_status),
    .write_status    (write_status),
    .payload_byte    (payload_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .issue_write     (issue_write),
    .byte_written    (byte_written),
    .tx_byte         (tx_byte),
    .clear_tx_done   (clear_tx_done),
    .clear_max_retry (clear_max_retry),
    .flush_tx        (flush_tx),
    .link_up         (link_up),
    .link_led        (link_led),
    .activity_led    (activity_led),
    .sent_total      (sent_total),
    .drop_total      (drop_total),
    .retries_used    (retries_used),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // Free-running clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A payload write: the byte goes out unless the write status reports a full FIFO.
  function automatic void load_payload(input poll_t p, inout result_t r);
    r.issue_write = 1'b1;
    if (!p.write_status[ST_TX_FULL_BIT]) begin
      r.byte_written = 1'b1;
      r.tx_byte = p.payload_byte;
      sup.activity_state = !sup.activity_state;
    end else begin
      if (p.write_status[ST_MAX_RT_BIT]) r.clear_max_retry = 1'b1;
      r.flush_tx = 1'b1;
    end
  endfunction

  // Works out the result of one poll and advances the shadow state.
  function automatic result_t supervise_poll(input poll_t p);
    result_t r;
    r = '0;
    if (sup.link_lost) begin
      if (!p.fifo_status[FF_TX_FULL_BIT]) load_payload(p, r);
      if (p.radio_status[ST_TX_DONE_BIT]) begin
        sup.link_led_state = 1'b1;
        r.clear_tx_done = 1'b1;
        sup.link_lost = 1'b0;
      end
      if (p.radio_status[ST_TX_FULL_BIT]) r.flush_tx = 1'b1;
      if (p.radio_status[ST_MAX_RT_BIT]) r.clear_max_retry = 1'b1;
    end else begin
      if (p.radio_status[ST_TX_DONE_BIT] && sup.payload_pending) begin
        sup.sent_counter = sup.sent_counter + 16'd1;
        sup.link_led_state = 1'b1;
        r.clear_tx_done = 1'b1;
        sup.payload_pending = 1'b0;
      end
      if ((p.radio_status & ST_PIPE_MASK) != 8'h00 && !sup.payload_pending &&
          p.fifo_status[FF_TX_EMPTY_BIT]) begin
        load_payload(p, r);
        sup.payload_pending = 1'b1;
      end
      if (p.radio_status[ST_MAX_RT_BIT]) begin
        sup.drop_counter = sup.drop_counter + 16'd1;
        sup.link_led_state = 1'b0;
        if (sup.retry_counter < retry_limit_shadow) begin
          r.clear_max_retry = 1'b1;
          sup.retry_counter = sup.retry_counter + 8'd1;
        end else begin
          sup.retry_counter = 8'd0;
          r.flush_tx = 1'b1;
          sup.payload_pending = 1'b0;
          sup.link_lost = 1'b1;
        end
      end
    end
    r.link_up = !sup.link_lost;
    r.link_led = sup.link_led_state;
    r.activity_led = sup.activity_state;
    r.sent_total = sup.sent_counter;
    r.drop_total = sup.drop_counter;
    r.retries_used = sup.retry_counter;
    return r;
  endfunction

  // Random poll with the status bits weighted so that links come up, fail and recover.
  function automatic poll_t random_poll(input int max_rt_pct);
    poll_t p;
    p.radio_status = 8'($urandom_range(255));
    p.fifo_status = 8'($urandom_range(255));
    p.write_status = 8'($urandom_range(255));
    p.payload_byte = 8'($urandom_range(255));
    if ($urandom_range(9) != 0) begin
      p.radio_status[ST_TX_DONE_BIT] = ($urandom_range(99) < 40);
      p.radio_status[ST_MAX_RT_BIT] = ($urandom_range(99) < max_rt_pct);
      p.radio_status[3:1] = ($urandom_range(99) < 65) ? 3'($urandom_range(1, 7)) : 3'd0;
      p.radio_status[ST_TX_FULL_BIT] = ($urandom_range(99) < 20);
      p.fifo_status[FF_TX_FULL_BIT] = ($urandom_range(99) < 20);
      p.fifo_status[FF_TX_EMPTY_BIT] = ($urandom_range(99) < 65);
      p.write_status[ST_TX_FULL_BIT] = ($urandom_range(99) < 20);
    end
    return p;
  endfunction

  // Presents one poll, holds it until accepted, then records its expected result.
  task automatic send_poll(input poll_t p);
    in_valid <= 1'b1;
    radio_status <= p.radio_status;
    fifo_status <= p.fifo_status;
    write_status <= p.write_status;
    payload_byte <= p.payload_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(supervise_poll(p));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_retry_limit(input logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    retry_limit_shadow = value;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: check each accepted beat and stall in runs of random length.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result beat with no poll outstanding");
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("issue_write", 16'(want.issue_write), 16'(issue_write));
        check_field("byte_written", 16'(want.byte_written), 16'(byte_written));
        check_field("tx_byte", 16'(want.tx_byte), 16'(tx_byte));
        check_field("clear_tx_done", 16'(want.clear_tx_done), 16'(clear_tx_done));
        check_field("clear_max_retry", 16'(want.clear_max_retry), 16'(clear_max_retry));
        check_field("flush_tx", 16'(want.flush_tx), 16'(flush_tx));
        check_field("link_up", 16'(want.link_up), 16'(link_up));
        check_field("link_led", 16'(want.link_led), 16'(link_led));
        check_field("activity_led", 16'(want.activity_led), 16'(activity_led));
        check_field("sent_total", want.sent_total, sent_total);
        check_field("drop_total", want.drop_total, drop_total);
        check_field("retries_used", 16'(want.retries_used), 16'(retries_used));
      end
    end
    if (stall_run == 0) begin
      stall_run <= $urandom_range(1, 12);
      out_stall <= ($urandom_range(99) < stall_pct);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // Link lost: FIFO full or not, write accepted or refused, several flag requests at once.
  task automatic test_link_lost_writes();
    stall_pct = 30;
    send_poll({8'h00, 8'h20, 8'h00, 8'h11});
    send_poll({8'h00, 8'h00, 8'h00, 8'hFF});
    send_poll({8'h00, 8'h00, 8'h01, 8'h00});
    send_poll({8'h00, 8'hDF, 8'h11, 8'h5A});
    send_poll({8'h11, 8'h20, 8'h00, 8'h33});
    send_poll({8'h00, 8'h00, 8'hFE, 8'h80});
    send_poll({8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  // Linked: one payload in flight, confirmation and a new write in one poll, refused write.
  task automatic test_linked_flow();
    send_poll({8'h02, 8'h10, 8'h00, 8'hA5});
    send_poll({8'h20, 8'h00, 8'h00, 8'h00});
    send_poll({8'h0E, 8'h10, 8'h01, 8'h3C});
    send_poll({8'h2E, 8'h10, 8'h00, 8'hC3});
    send_poll({8'h2E, 8'hEF, 8'h00, 8'h01});
    send_poll({8'h10, 8'h00, 8'h00, 8'h00});
    send_poll({8'h3F, 8'h30, 8'h10, 8'h7E});
    send_poll({8'h00, 8'h00, 8'h00, 8'h00});
  endtask

  // A limit of zero drops the link on the first failure; a limit of one on the second.
  task automatic test_retry_limit_extremes();
    write_retry_limit(8'd0);
    send_poll({8'h20, 8'h00, 8'h00, 8'h42});
    send_poll({8'h10, 8'h00, 8'h00, 8'h00});
    send_poll({8'h20, 8'h00, 8'h00, 8'h24});
    write_retry_limit(8'd1);
    send_poll({8'h12, 8'h10, 8'h00, 8'h99});
    send_poll({8'h10, 8'h00, 8'h00, 8'h00});
    send_poll({8'h20, 8'h00, 8'h00, 8'h00});
  endtask

  // Back-to-back confirmations and failures at the widest limit with no receiver stalls.
  task automatic test_back_to_back();
    write_retry_limit(8'd255);
    stall_pct = 0;
    for (int i = 0; i < 40; i++) begin
      send_poll({8'h32, 8'h10, 8'h00, 8'(i)});
    end
    write_retry_limit(8'd20);
  endtask

  // Random traffic in phases of differing limit, receiver stalls and failure rate.
  task automatic test_random_traffic();
    int limits[5];
    int stalls[5] = '{0, 30, 60, 15, 45};
    int max_rt[5] = '{15, 25, 10, 35, 20};
    int sent;
    int burst;
    limits = '{$urandom_range(2, 40), 0, 255, 1, $urandom_range(255)};
    for (int ph = 0; ph < 5; ph++) begin
      write_retry_limit(8'(limits[ph]));
      stall_pct = stalls[ph];
      sent = 0;
      while (sent < 220) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < 220; k++) begin
          send_poll(random_poll(max_rt[ph]));
          sent++;
        end
        if ($urandom_range(49) == 0) wait_drained();
        else idle_cycles($urandom_range(0, 6));
      end
    end
  endtask

  initial begin
    sup = '0;
    sup.link_lost = 1'b1;
    retry_limit_shadow = 8'd20;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_link_lost_writes();
    test_linked_flow();
    test_retry_limit_extremes();
    test_back_to_back();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** radio_tx_link_supervisor: PASSED **");
    end else begin
      $display("** radio_tx_link_supervisor: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("** radio_tx_link_supervisor: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
src/rtls_pkg.sv
src/rtls_step.sv
src/radio_tx_link_supervisor.sv
verif/tb_radio_tx_link_supervisor.sv
